// ===== hdl/fpdta_pkg.sv =====
package fpdta_pkg;

    localparam int unsigned VALUE_W  = 17;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned DIGITS   = 5;
    localparam int unsigned BCD_W    = 4 * DIGITS;

    // the first three shifts can never need a digit correction
    localparam int unsigned PRESHIFT     = 3;
    localparam int unsigned DABBLE_STEPS = 7;

    localparam logic [VALUE_W-1:0] SAT_MAX     = 17'd99999;
    localparam logic [CHAR_W-1:0]  ASCII_POINT = 7'd46;
    localparam logic [2:0]         ASCII_DIGIT_HI = 3'b011;

    // character positions within one run
    localparam logic [2:0] POS_D4    = 3'd0;
    localparam logic [2:0] POS_D3    = 3'd1;
    localparam logic [2:0] POS_POINT = 3'd2;
    localparam logic [2:0] POS_D2    = 3'd3;
    localparam logic [2:0] POS_D1    = 3'd4;
    localparam logic [2:0] POS_D0    = 3'd5;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } t_word;

    typedef struct packed {
        logic  v;
        t_word w;
    } t_stage;

    // one shift-add-3 step
    function automatic t_word dabble_step(t_word w);
        t_word c;
        c = w;
        for (int i = 0; i < DIGITS; i++) begin
            if (c.bcd[4*i +: 4] >= 4'd5) begin
                c.bcd[4*i +: 4] = c.bcd[4*i +: 4] + 4'd3;
            end
        end
        return t_word'({c.bcd, c.bin} << 1);
    endfunction

endpackage

// ===== hdl/fpdta_front.sv =====
module fpdta_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic                            i_adv,
    input  logic [fpdta_pkg::VALUE_W-1:0]   i_value,
    output fpdta_pkg::t_stage               o_stage
);

    fpdta_pkg::t_stage r_stage;
    fpdta_pkg::t_stage n_stage;
    logic [fpdta_pkg::VALUE_W-1:0] sat;

    always_comb begin
        sat = (i_value > fpdta_pkg::SAT_MAX) ? fpdta_pkg::SAT_MAX : i_value;
        n_stage = r_stage;
        if (i_load) begin
            n_stage.v = 1'b1;
            // pre-shift by three, no correction possible yet
            n_stage.w.bcd = {{(fpdta_pkg::BCD_W - fpdta_pkg::PRESHIFT){1'b0}},
                             sat[fpdta_pkg::VALUE_W-1 -: fpdta_pkg::PRESHIFT]};
            n_stage.w.bin = {sat[fpdta_pkg::VALUE_W-fpdta_pkg::PRESHIFT-1:0],
                             {fpdta_pkg::PRESHIFT{1'b0}}};
        end else if (i_adv) begin
            n_stage.v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.v <= 1'b0;
        end else begin
            r_stage.v <= n_stage.v;
        end
        r_stage.w <= n_stage.w;
    end

    assign o_stage = r_stage;

endmodule

// ===== hdl/fpdta_dabble.sv =====
module fpdta_dabble (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  fpdta_pkg::t_stage i_stage,
    output fpdta_pkg::t_stage o_stage
);

    fpdta_pkg::t_stage r_stage;
    fpdta_pkg::t_word  n_word;

    always_comb begin
        n_word = i_stage.w;
        for (int s = 0; s < fpdta_pkg::DABBLE_STEPS; s++) begin
            n_word = fpdta_pkg::dabble_step(n_word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.v <= 1'b0;
        end else if (i_adv) begin
            r_stage.v <= i_stage.v;
        end
        if (i_adv) begin
            r_stage.w <= n_word;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hdl/fpdta_serial.sv =====
module fpdta_serial (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fpdta_pkg::t_stage              i_stage,
    output logic                           o_free,
    output logic                           o_strobe,
    output logic [fpdta_pkg::CHAR_W-1:0]   o_ascii_char,
    output logic                           o_last
);

    logic                          r_sv;
    logic [2:0]                    r_pos;
    logic [fpdta_pkg::BCD_W-1:0]   r_bcd;
    logic [2:0]                    n_pos;
    logic [3:0]                    digit;

    assign o_free = !r_sv || (r_pos == fpdta_pkg::POS_D0);

    always_comb begin
        if (r_pos == fpdta_pkg::POS_D0) begin
            n_pos = fpdta_pkg::POS_D0;
        end else begin
            n_pos = r_pos + 3'd1;
        end
        if (o_free) begin
            // skip a zero ten-thousands digit
            n_pos = (i_stage.w.bcd[19:16] != 4'd0) ? fpdta_pkg::POS_D4
                                                   : fpdta_pkg::POS_D3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (o_free) begin
            r_sv <= i_stage.v;
        end
        r_pos <= n_pos;
        if (o_free) begin
            r_bcd <= i_stage.w.bcd;
        end
    end

    always_comb begin
        case (r_pos)
            fpdta_pkg::POS_D4: digit = r_bcd[19:16];
            fpdta_pkg::POS_D3: digit = r_bcd[15:12];
            fpdta_pkg::POS_D2: digit = r_bcd[11:8];
            fpdta_pkg::POS_D1: digit = r_bcd[7:4];
            default:           digit = r_bcd[3:0];
        endcase
        if (r_pos == fpdta_pkg::POS_POINT) begin
            o_ascii_char = fpdta_pkg::ASCII_POINT;
        end else begin
            o_ascii_char = {fpdta_pkg::ASCII_DIGIT_HI, digit};
        end
    end

    assign o_strobe = r_sv;
    assign o_last   = r_sv && (r_pos == fpdta_pkg::POS_D0);

endmodule

// ===== hdl/fixed_point_decimal_to_ascii.sv =====
// path: an accepted item is registered in front, both dabble stages, then the serializer
// throughput: an item is 5 characters (value below 10000) or 6 (ten-thousands digit shown),
//   set by the character serializer that sends one character per cycle
// reset: synchronous active-low i_rst_n clears all valid bits; nothing else needs reset
// the receiver cannot stall: each character is held for exactly one cycle under o_strobe
module fixed_point_decimal_to_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fpdta_pkg::VALUE_W-1:0] i_value,
    output logic                          o_strobe,
    output logic [fpdta_pkg::CHAR_W-1:0]  o_ascii_char,
    output logic                          o_last
);

    // pipeline: saturate + pre-shift, two double-dabble stages of seven steps each,
    // then the serializer that walks the digits and the decimal point
    fpdta_pkg::t_stage front_q;
    fpdta_pkg::t_stage mid_q;
    fpdta_pkg::t_stage back_q;
    logic              ser_free;
    logic              adv;
    logic              accept;

    // the whole conversion pipe moves together whenever its tail can hand off
    assign adv    = !back_q.v || ser_free;
    // an empty front stage can always take an item, even while the rest holds
    assign busy   = front_q.v && !adv;
    assign accept = start && !busy;

    fpdta_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_adv   (adv),
        .i_value (i_value),
        .o_stage (front_q)
    );

    fpdta_dabble u_dabble_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_stage (front_q),
        .o_stage (mid_q)
    );

    fpdta_dabble u_dabble_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_stage (mid_q),
        .o_stage (back_q)
    );

    // serializer loads a fresh item on the cycle its last character goes out
    fpdta_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (back_q),
        .o_free       (ser_free),
        .o_strobe     (o_strobe),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

endmodule
